>>> hw/rtl/npt_pkg.sv
// npt_pkg: shared types and constants for the node position table.
// Used by npt_entry_mem, npt_match, node_position_table and the testbench.
// No dependencies.
package npt_pkg;

    // Default table depth
    localparam int ENTRIES_DEF = 9;

    // Command codes
    localparam logic [1:0] CMD_UPDATE    = 2'd0;
    localparam logic [1:0] CMD_FIND_ID   = 2'd1;
    localparam logic [1:0] CMD_FIND_GRID = 2'd2;
    localparam logic [1:0] CMD_CLEAR     = 2'd3;

    // Reported slot index width and count ceiling
    localparam int         SLOT_W    = 4;
    localparam int         COUNT_W   = 4;
    localparam logic [3:0] COUNT_MAX = 4'd15;

    // One stored placement
    typedef struct packed {
        logic [15:0]       node;
        logic [1:0]        kind;
        logic [2:0]        turn;
        logic signed [3:0] gx;
        logic signed [3:0] gy;
        logic [7:0]        ox;
        logic [7:0]        oy;
    } entry_t;

endpackage

>>> hw/rtl/node_position_table.sv
// node_position_table: clear drops the changed flag; result is shown the next cycle.
// Other commands scan entries 0..fill-1 through one compare unit, one entry a cycle,
// behind the memory's registered read, stopping at the first hit or the last claimed
// entry; the next transaction is taken the cycle after the result is taken, so only
// one transaction is in flight at a time.
// Reset (async, active low) empties the table at once through the fill count.
module node_position_table #(
    parameter int ENTRIES = npt_pkg::ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic        [1:0] command,
    input  logic       [15:0] node_id,
    input  logic        [7:0] type_byte,
    input  logic        [7:0] rotation_byte,
    input  logic        [7:0] grid_byte,
    input  logic        [7:0] offset_x_byte,
    input  logic        [7:0] offset_y_byte,
    input  logic signed [3:0] query_x,
    input  logic signed [3:0] query_y,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              found,
    output logic        [3:0] slot,
    output logic       [15:0] entry_id,
    output logic        [1:0] entry_type,
    output logic        [2:0] entry_rotation,
    output logic signed [3:0] entry_grid_x,
    output logic signed [3:0] entry_grid_y,
    output logic        [7:0] entry_offset_x,
    output logic        [7:0] entry_offset_y,
    output logic        [3:0] valid_count,
    output logic              changed,
    output logic              full_error
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int SLOT_W = npt_pkg::SLOT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // Control state
    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             changed_reg, changed_next;

    // Transaction payload and result
    logic [1:0]        cmd_reg, cmd_next;
    npt_pkg::entry_t   new_reg, new_next;
    logic signed [3:0] qx_reg, qx_next;
    logic signed [3:0] qy_reg, qy_next;
    logic              found_reg, found_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    npt_pkg::entry_t   res_reg, res_next;
    logic              full_reg, full_next;

    // Memory and compare unit hookup
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    npt_pkg::entry_t  rd_data;
    logic             hit;

    logic [IDX_W+SLOT_W-1:0] rd_idx_ext;
    logic [IDX_W+SLOT_W-1:0] fill_idx_ext;
    logic [CNT_W+npt_pkg::COUNT_W-1:0] fill_ext;

    logic in_fire;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_DONE);
    assign in_fire   = in_valid && in_ready;

    assign rd_idx_ext   = {{SLOT_W{1'b0}}, rd_idx_reg};
    assign fill_idx_ext = {{SLOT_W{1'b0}}, fill_reg[IDX_W-1:0]};
    assign fill_ext     = {{npt_pkg::COUNT_W{1'b0}}, fill_reg};

    npt_entry_mem #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (new_reg),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    npt_match u_match (
        .cmd    (cmd_reg),
        .key_id (new_reg.node),
        .key_x  (qx_reg),
        .key_y  (qy_reg),
        .entry  (rd_data),
        .hit    (hit)
    );

    // Sequencer: accept, scan with one read in flight, finish, hand off
    always_comb
    begin
        state_next    = state_reg;
        issue_next    = issue_reg;
        rd_valid_next = rd_valid_reg;
        rd_idx_next   = rd_idx_reg;
        fill_next     = fill_reg;
        changed_next  = changed_reg;
        cmd_next      = cmd_reg;
        new_next      = new_reg;
        qx_next       = qx_reg;
        qy_next       = qy_reg;
        found_next    = found_reg;
        slot_next     = slot_reg;
        res_next      = res_reg;
        full_next     = full_reg;
        wr_en         = 1'b0;
        wr_addr       = rd_idx_reg;
        rd_en         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next      = command;
                    new_next.node = node_id;
                    new_next.kind = type_byte[1:0];
                    new_next.turn = rotation_byte[2:0];
                    new_next.gx   = grid_byte[3:0];
                    new_next.gy   = grid_byte[7:4];
                    new_next.ox   = offset_x_byte;
                    new_next.oy   = offset_y_byte;
                    qx_next       = query_x;
                    qy_next       = query_y;
                    found_next    = 1'b0;
                    slot_next     = '0;
                    res_next      = '0;
                    full_next     = 1'b0;
                    issue_next    = '0;
                    rd_valid_next = 1'b0;
                    if (command == npt_pkg::CMD_CLEAR)
                    begin
                        changed_next = 1'b0;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        if (command == npt_pkg::CMD_UPDATE)
                        begin
                            changed_next = 1'b1;
                        end
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (rd_valid_reg && hit)
                begin
                    // First matching entry
                    found_next = 1'b1;
                    slot_next  = rd_idx_ext[SLOT_W-1:0];
                    if (cmd_reg == npt_pkg::CMD_UPDATE)
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = rd_idx_reg;
                        res_next = new_reg;
                    end
                    else
                    begin
                        res_next = rd_data;
                    end
                    rd_valid_next = 1'b0;
                    state_next    = ST_DONE;
                end
                else if (!rd_valid_reg && (issue_reg >= fill_reg))
                begin
                    // All claimed entries checked without a match
                    if (cmd_reg == npt_pkg::CMD_UPDATE)
                    begin
                        if (fill_reg < CNT_W'(ENTRIES))
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = fill_reg[IDX_W-1:0];
                            fill_next  = fill_reg + 1'b1;
                            found_next = 1'b1;
                            slot_next  = fill_idx_ext[SLOT_W-1:0];
                            res_next   = new_reg;
                        end
                        else
                        begin
                            full_next = 1'b1;
                        end
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    // Issue next read while comparing the previous one
                    rd_en         = (issue_reg < fill_reg);
                    rd_valid_next = rd_en;
                    rd_idx_next   = issue_reg[IDX_W-1:0];
                    if (rd_en)
                    begin
                        issue_next = issue_reg + 1'b1;
                    end
                end
            end

            ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            issue_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_idx_reg   <= '0;
            fill_reg     <= '0;
            changed_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            issue_reg    <= issue_next;
            rd_valid_reg <= rd_valid_next;
            rd_idx_reg   <= rd_idx_next;
            fill_reg     <= fill_next;
            changed_reg  <= changed_next;
        end
    end

    // Payload and result registers
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        new_reg   <= new_next;
        qx_reg    <= qx_next;
        qy_reg    <= qy_next;
        found_reg <= found_next;
        slot_reg  <= slot_next;
        res_reg   <= res_next;
        full_reg  <= full_next;
    end

    // Result ports
    assign found          = found_reg;
    assign slot           = slot_reg;
    assign entry_id       = res_reg.node;
    assign entry_type     = res_reg.kind;
    assign entry_rotation = res_reg.turn;
    assign entry_grid_x   = res_reg.gx;
    assign entry_grid_y   = res_reg.gy;
    assign entry_offset_x = res_reg.ox;
    assign entry_offset_y = res_reg.oy;
    assign changed        = changed_reg;
    assign full_error     = full_reg;

    // Claimed count, saturating
    assign valid_count = (fill_ext > (CNT_W + npt_pkg::COUNT_W)'(npt_pkg::COUNT_MAX))
                         ? npt_pkg::COUNT_MAX
                         : fill_ext[npt_pkg::COUNT_W-1:0];

endmodule

>>> hw/rtl/npt_entry_mem.sv
// npt_entry_mem: placement storage, one write port and one registered read port.
// Depends on npt_pkg (entry_t, ENTRIES_DEF).
// Contents are undefined until written; validity is tracked by the fill count.
module npt_entry_mem #(
    parameter int ENTRIES = npt_pkg::ENTRIES_DEF,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic               clk,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_addr,
    input  npt_pkg::entry_t    wr_data,
    input  logic               rd_en,
    input  logic [IDX_W-1:0]   rd_addr,
    output npt_pkg::entry_t    rd_data
);

    npt_pkg::entry_t mem [ENTRIES];
    npt_pkg::entry_t rd_data_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/npt_match.sv
// npt_match: shared key compare unit, reused for every entry of a scan.
// Depends on npt_pkg (entry_t, command codes).
// Update and find-by-id match on node id; find-by-grid matches on grid x and y.
module npt_match (
    input  logic               [1:0] cmd,
    input  logic              [15:0] key_id,
    input  logic signed        [3:0] key_x,
    input  logic signed        [3:0] key_y,
    input  npt_pkg::entry_t          entry,
    output logic                     hit
);

    // Select the key by command
    always_comb
    begin
        case (cmd)
            npt_pkg::CMD_UPDATE,
            npt_pkg::CMD_FIND_ID:   hit = (entry.node == key_id);
            npt_pkg::CMD_FIND_GRID: hit = (entry.gx == key_x) && (entry.gy == key_y);
            default:                hit = 1'b0;
        endcase
    end

endmodule

>>> hw/rtl/npt_checker.sv
// npt_checker: port-level assertions for node_position_table, bound to the top level.
// No package dependency; sees only the top level's ports.
// Checks the one-at-a-time handshake, result hold, result consistency and the count.
module npt_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_ready,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic              found,
    input  logic        [3:0] slot,
    input  logic       [15:0] entry_id,
    input  logic        [1:0] entry_type,
    input  logic        [2:0] entry_rotation,
    input  logic signed [3:0] entry_grid_x,
    input  logic signed [3:0] entry_grid_y,
    input  logic        [7:0] entry_offset_x,
    input  logic        [7:0] entry_offset_y,
    input  logic        [3:0] valid_count,
    input  logic              changed,
    input  logic              full_error
);

    // One transaction in flight: never ready while a result is shown
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result is pending");

    // A stalled result stays valid and unchanged
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid &&
            $stable({found, slot, entry_id, entry_type, entry_rotation, entry_grid_x,
                     entry_grid_y, entry_offset_x, entry_offset_y, valid_count,
                     changed, full_error})))
        else $error("result changed or dropped while stalled");

    // A full-table update writes nothing and still marks the table changed
    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && full_error) |-> (!found && changed))
        else $error("full error with found set or changed clear");

    // A miss reports an all-zero entry
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (slot == 4'd0 && entry_id == 16'd0 &&
                                   entry_type == 2'd0 && entry_rotation == 3'd0 &&
                                   entry_grid_x == 4'sd0 && entry_grid_y == 4'sd0 &&
                                   entry_offset_x == 8'd0 && entry_offset_y == 8'd0))
        else $error("miss reports nonzero entry fields");

    // Entries are never released: the claimed count never falls
    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (valid_count >= $past(valid_count)))
        else $error("claimed count decreased");

endmodule

bind node_position_table npt_checker u_npt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .found          (found),
    .slot           (slot),
    .entry_id       (entry_id),
    .entry_type     (entry_type),
    .entry_rotation (entry_rotation),
    .entry_grid_x   (entry_grid_x),
    .entry_grid_y   (entry_grid_y),
    .entry_offset_x (entry_offset_x),
    .entry_offset_y (entry_offset_y),
    .valid_count    (valid_count),
    .changed        (changed),
    .full_error     (full_error)
);

>>> verif/tb_node_position_table.sv
// tb_node_position_table: self-checking testbench for node_position_table.
// A directed table of commands is followed by random traffic. Every result is
// compared with a hand-written report or a behavioral copy of the table. Depends on npt_pkg and the RTL.
module tb_node_position_table;

    localparam int ENTRIES     = npt_pkg::ENTRIES_DEF;
    localparam int RANDOM_CMDS = 626;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_SHOWN   = 10;
    localparam int DRAIN       = ENTRIES + 8;

    // One command transaction as driven on the input channel
    typedef struct packed {
        logic [1:0]        cmd;
        logic [15:0]       id;
        logic [7:0]        tbyte;
        logic [7:0]        rbyte;
        logic [7:0]        gbyte;
        logic [7:0]        oxb;
        logic [7:0]        oyb;
        logic signed [3:0] qx;
        logic signed [3:0] qy;
    } page_cmd_t;

    // One result transaction
    typedef struct packed {
        logic              found;
        logic [3:0]        slot;
        logic [15:0]       id;
        logic [1:0]        kind;
        logic [2:0]        turn;
        logic signed [3:0] gx;
        logic signed [3:0] gy;
        logic [7:0]        ox;
        logic [7:0]        oy;
        logic [3:0]        count;
        logic              changed;
        logic              full;
    } lookup_report_t;

    // Directed row: a command and, where obvious, its hand-written report
    typedef struct {
        page_cmd_t      c;
        bit             typed;
        lookup_report_t r;
    } directed_row_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic        [1:0] command;
    logic       [15:0] node_id;
    logic        [7:0] type_byte;
    logic        [7:0] rotation_byte;
    logic        [7:0] grid_byte;
    logic        [7:0] offset_x_byte;
    logic        [7:0] offset_y_byte;
    logic signed [3:0] query_x;
    logic signed [3:0] query_y;
    logic              out_valid;
    logic              out_ready;
    logic              found;
    logic        [3:0] slot;
    logic       [15:0] entry_id;
    logic        [1:0] entry_type;
    logic        [2:0] entry_rotation;
    logic signed [3:0] entry_grid_x;
    logic signed [3:0] entry_grid_y;
    logic        [7:0] entry_offset_x;
    logic        [7:0] entry_offset_y;
    logic        [3:0] valid_count;
    logic              changed;
    logic              full_error;

    // Shadow copy of the table
    npt_pkg::entry_t placed [ENTRIES];
    bit              slot_used [ENTRIES];
    logic [3:0]      claimed;
    logic            dirty;

    lookup_report_t awaited_reports [$];
    directed_row_t  directed_rows [24];
    int             fail_count;
    int             shown_count;
    int             burst_left;
    int             cycle_count;
    int             rx_tick;
    int             rx_mode;
    logic [7:0]     rx_mask;

    node_position_table DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .node_id        (node_id),
        .type_byte      (type_byte),
        .rotation_byte  (rotation_byte),
        .grid_byte      (grid_byte),
        .offset_x_byte  (offset_x_byte),
        .offset_y_byte  (offset_y_byte),
        .query_x        (query_x),
        .query_y        (query_y),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .slot           (slot),
        .entry_id       (entry_id),
        .entry_type     (entry_type),
        .entry_rotation (entry_rotation),
        .entry_grid_x   (entry_grid_x),
        .entry_grid_y   (entry_grid_y),
        .entry_offset_x (entry_offset_x),
        .entry_offset_y (entry_offset_y),
        .valid_count    (valid_count),
        .changed        (changed),
        .full_error     (full_error)
    );

    // Clock: period 20
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // First valid slot holding this id, or -1
    function automatic int slot_of_node(logic [15:0] id);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (slot_used[i] && placed[i].node == id)
                return i;
        end
        return -1;
    endfunction

    // Apply one command to the shadow table and return the report it yields
    function automatic lookup_report_t apply_command(page_cmd_t c);
        lookup_report_t r;
        int             hit;
        logic           no_room;
        r       = '0;
        hit     = -1;
        no_room = 1'b0;
        case (c.cmd)
            npt_pkg::CMD_UPDATE:
            begin
                dirty = 1'b1;
                hit   = slot_of_node(c.id);
                if (hit < 0)
                begin
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (hit < 0 && !slot_used[i])
                            hit = i;
                    end
                    if (hit >= 0)
                    begin
                        slot_used[hit]   = 1'b1;
                        placed[hit].node = c.id;
                        if (claimed < npt_pkg::COUNT_MAX)
                            claimed = claimed + 4'd1;
                    end
                end
                if (hit < 0)
                    no_room = 1'b1;
                else
                begin
                    placed[hit].kind = c.tbyte[1:0];
                    placed[hit].turn = c.rbyte[2:0];
                    placed[hit].gx   = c.gbyte[3:0];
                    placed[hit].gy   = c.gbyte[7:4];
                    placed[hit].ox   = c.oxb;
                    placed[hit].oy   = c.oyb;
                end
            end
            npt_pkg::CMD_FIND_ID:
                hit = slot_of_node(c.id);
            npt_pkg::CMD_FIND_GRID:
            begin
                for (int i = ENTRIES - 1; i >= 0; i--)
                begin
                    if (slot_used[i] && placed[i].gx == c.qx && placed[i].gy == c.qy)
                        hit = i;
                end
            end
            default:
                dirty = 1'b0;
        endcase
        if (hit >= 0)
        begin
            r.found = 1'b1;
            r.slot  = 4'(hit);
            r.id    = placed[hit].node;
            r.kind  = placed[hit].kind;
            r.turn  = placed[hit].turn;
            r.gx    = placed[hit].gx;
            r.gy    = placed[hit].gy;
            r.ox    = placed[hit].ox;
            r.oy    = placed[hit].oy;
        end
        r.count   = claimed;
        r.changed = dirty;
        r.full    = no_room;
        return r;
    endfunction

    function automatic string show(lookup_report_t r);
        return $sformatf({"found=%0d slot=%0d id=%h type=%0d rot=%0d gx=%0d gy=%0d ",
                          "ox=%h oy=%h count=%0d changed=%0d full=%0d"},
                         r.found, r.slot, r.id, r.kind, r.turn, r.gx, r.gy,
                         r.ox, r.oy, r.count, r.changed, r.full);
    endfunction

    task automatic note_mismatch(string what);
        fail_count++;
        if (shown_count < MAX_SHOWN)
        begin
            shown_count++;
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // Drive one command at a falling edge; sender works in bursts with gaps
    task automatic send_command(page_cmd_t c, bit typed, lookup_report_t typed_r);
        int             gap;
        lookup_report_t predicted;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        command       <= c.cmd;
        node_id       <= c.id;
        type_byte     <= c.tbyte;
        rotation_byte <= c.rbyte;
        grid_byte     <= c.gbyte;
        offset_x_byte <= c.oxb;
        offset_y_byte <= c.oyb;
        query_x       <= c.qx;
        query_y       <= c.qy;
        in_valid      <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = apply_command(c);
        awaited_reports.push_back(typed ? typed_r : predicted);
        burst_left--;
        @(negedge clk);
    endtask

    // Random command, biased toward ids and grid cells that are in the table
    function automatic page_cmd_t random_command();
        page_cmd_t c;
        int        pick;
        int        pool;
        pick    = $urandom_range(0, 19);
        pool    = (claimed > ENTRIES) ? ENTRIES : int'(claimed);
        c.cmd   = (pick < 8)  ? npt_pkg::CMD_UPDATE :
                  (pick < 13) ? npt_pkg::CMD_FIND_ID :
                  (pick < 18) ? npt_pkg::CMD_FIND_GRID : npt_pkg::CMD_CLEAR;
        c.id    = 16'($urandom);
        c.tbyte = 8'($urandom);
        c.rbyte = 8'($urandom);
        c.gbyte = 8'($urandom);
        c.oxb   = 8'($urandom);
        c.oyb   = 8'($urandom);
        c.qx    = 4'($urandom);
        c.qy    = 4'($urandom);
        if (pool > 0)
        begin
            pick = $urandom_range(0, pool - 1);
            if ($urandom_range(0, 9) < 7)
                c.id = placed[pick].node;
            if ($urandom_range(0, 9) < 6)
            begin
                c.qx = placed[pick].gx;
                c.qy = placed[pick].gy;
            end
        end
        return c;
    endfunction

    // Receiver: ready pattern redrawn whenever the rx_tick counter wraps
    always @(negedge clk)
    begin
        if (rx_tick == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_mask = 8'($urandom);
        end
        rx_tick = (rx_tick + 1) % 40;
        case (rx_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= rx_mask[rx_tick % 8];
            default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin : result_check
        lookup_report_t seen;
        lookup_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            seen = '{found, slot, entry_id, entry_type, entry_rotation, entry_grid_x,
                     entry_grid_y, entry_offset_x, entry_offset_y, valid_count,
                     changed, full_error};
            if (awaited_reports.size() == 0)
                note_mismatch({"unexpected result ", show(seen)});
            else
            begin
                want = awaited_reports.pop_front();
                if (seen !== want)
                    note_mismatch({"expected ", show(want), " got ", show(seen)});
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        out_ready     = 1'b0;
        command       = npt_pkg::CMD_FIND_ID;
        node_id       = '0;
        type_byte     = '0;
        rotation_byte = '0;
        grid_byte     = '0;
        offset_x_byte = '0;
        offset_y_byte = '0;
        query_x       = '0;
        query_y       = '0;
        fail_count    = 0;
        shown_count   = 0;
        burst_left    = 0;
        cycle_count   = 0;
        rx_tick       = 0;
        rx_mode       = 0;
        rx_mask       = '1;
        claimed       = '0;
        dirty         = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            placed[i]    = '0;
            slot_used[i] = 1'b0;
        end

        // Empty table: lookups and clear report nothing
        directed_rows[0]  = '{'{npt_pkg::CMD_FIND_ID, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
                                 8'h00, 4'sd0, 4'sd0}, 1'b1, '0};
        directed_rows[1]  = '{'{npt_pkg::CMD_FIND_GRID, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
                                 8'h00, 4'sd0, 4'sd0}, 1'b1, '0};
        directed_rows[2]  = '{'{npt_pkg::CMD_CLEAR, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
                                 8'h00, 4'sd0, 4'sd0}, 1'b1, '0};
        // All-ones page into the first slot, grid at the negative extreme
        directed_rows[3]  = '{'{npt_pkg::CMD_UPDATE, 16'hFFFF, 8'hFF, 8'hFF, 8'h88, 8'hFF,
                                 8'hFF, -4'sd1, -4'sd1}, 1'b1,
                              '{1'b1, 4'd0, 16'hFFFF, 2'd3, 3'd7, -4'sd8, -4'sd8,
                                8'hFF, 8'hFF, 4'd1, 1'b1, 1'b0}};
        directed_rows[4]  = '{'{npt_pkg::CMD_UPDATE, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
                                 8'h00, 4'sd0, 4'sd0}, 1'b1,
                              '{1'b1, 4'd1, 16'h0000, 2'd0, 3'd0, 4'sd0, 4'sd0,
                                8'h00, 8'h00, 4'd2, 1'b1, 1'b0}};
        // Same id again rewrites slot 0, grid at the positive extreme
        directed_rows[5]  = '{'{npt_pkg::CMD_UPDATE, 16'hFFFF, 8'h01, 8'h02, 8'h77, 8'h12,
                                 8'h34, 4'sd0, 4'sd0}, 1'b0, '0};
        // Fill the rest of the table
        directed_rows[6]  = '{'{npt_pkg::CMD_UPDATE, 16'h0001, 8'hFE, 8'hFD, 8'h1F, 8'h80,
                                 8'h01, 4'sd0, 4'sd0}, 1'b0, '0};
        directed_rows[7]  = '{'{npt_pkg::CMD_UPDATE, 16'h0002, 8'h02, 8'h05, 8'hF1, 8'h7F,
                                 8'hFE, 4'sd0, 4'sd0}, 1'b0, '0};
        directed_rows[8]  = '{'{npt_pkg::CMD_UPDATE, 16'h0003, 8'h03, 8'h06, 8'h80, 8'h55,
                                 8'hAA, 4'sd0, 4'sd0}, 1'b0, '0};
        directed_rows[9]  = '{'{npt_pkg::CMD_UPDATE, 16'h0004, 8'h81, 8'h03, 8'h08, 8'hAA,
                                 8'h55, 4'sd0, 4'sd0}, 1'b0, '0};
        directed_rows[10] = '{'{npt_pkg::CMD_UPDATE, 16'h8005, 8'h40, 8'h01, 8'h5A, 8'h0F,
                                 8'hF0, 4'sd0, 4'sd0}, 1'b0, '0};
        directed_rows[11] = '{'{npt_pkg::CMD_UPDATE, 16'h0006, 8'h22, 8'h44, 8'hA5, 8'hF0,
                                 8'h0F, 4'sd0, 4'sd0}, 1'b0, '0};
        directed_rows[12] = '{'{npt_pkg::CMD_UPDATE, 16'h7FFF, 8'h11, 8'hF8, 8'h33, 8'h3C,
                                 8'hC3, 4'sd0, 4'sd0}, 1'b0, '0};
        // Table full: new id is refused but still marks the table changed
        directed_rows[13] = '{'{npt_pkg::CMD_UPDATE, 16'h1234, 8'h03, 8'h07, 8'h99, 8'h11,
                                 8'h22, 4'sd0, 4'sd0}, 1'b1,
                              '{1'b0, 4'd0, 16'h0000, 2'd0, 3'd0, 4'sd0, 4'sd0,
                                8'h00, 8'h00, 4'd9, 1'b1, 1'b1}};
        directed_rows[14] = '{'{npt_pkg::CMD_CLEAR, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                 8'hFF, -4'sd1, -4'sd1}, 1'b1,
                              '{1'b0, 4'd0, 16'h0000, 2'd0, 3'd0, 4'sd0, 4'sd0,
                                8'h00, 8'h00, 4'd9, 1'b0, 1'b0}};
        directed_rows[15] = '{'{npt_pkg::CMD_FIND_ID, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00,
                                 8'h00, 4'sd0, 4'sd0}, 1'b0, '0};
        directed_rows[16] = '{'{npt_pkg::CMD_FIND_ID, 16'h5555, 8'h00, 8'h00, 8'h00, 8'h00,
                                 8'h00, 4'sd0, 4'sd0}, 1'b1,
                              '{1'b0, 4'd0, 16'h0000, 2'd0, 3'd0, 4'sd0, 4'sd0,
                                8'h00, 8'h00, 4'd9, 1'b0, 1'b0}};
        // Known id still updates in place when the table is full
        directed_rows[17] = '{'{npt_pkg::CMD_UPDATE, 16'h0003, 8'h01, 8'h04, 8'hC6, 8'h99,
                                 8'h66, 4'sd0, 4'sd0}, 1'b0, '0};
        // Grid lookups: hits, a miss, sign handling
        directed_rows[18] = '{'{npt_pkg::CMD_FIND_GRID, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
                                 8'h00, 4'sd7, 4'sd7}, 1'b0, '0};
        directed_rows[19] = '{'{npt_pkg::CMD_FIND_GRID, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
                                 8'h00, -4'sd8, -4'sd8}, 1'b1,
                              '{1'b0, 4'd0, 16'h0000, 2'd0, 3'd0, 4'sd0, 4'sd0,
                                8'h00, 8'h00, 4'd9, 1'b1, 1'b0}};
        directed_rows[20] = '{'{npt_pkg::CMD_FIND_GRID, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
                                 8'h00, 4'sd0, -4'sd8}, 1'b0, '0};
        directed_rows[21] = '{'{npt_pkg::CMD_FIND_GRID, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
                                 8'h00, -4'sd1, 4'sd1}, 1'b0, '0};
        directed_rows[22] = '{'{npt_pkg::CMD_FIND_ID, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
                                 8'h00, 4'sd0, 4'sd0}, 1'b0, '0};
        directed_rows[23] = '{'{npt_pkg::CMD_CLEAR, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
                                 8'h00, 4'sd0, 4'sd0}, 1'b0, '0};

        // Reset, released on a falling edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_command(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].r);
        repeat (RANDOM_CMDS)
            send_command(random_command(), 1'b0, '0);
        in_valid <= 1'b0;

        // Drain outstanding results, then watch for stray ones
        while (awaited_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
